// File: design/pivc_pkg.sv
// ============================================================================
// pivc_pkg: shared types, constants and microcode for the PI velocity core
// Holds the beat payload structs, the datapath widths derived from the
// integrator width, the register index codes and the control store.
// ============================================================================
package pivc_pkg;

    // Integrator width (signed Q16.16 at the default of 32 bits).
    localparam int INT_W     = 32;
    // Width of the proportional plus integral sum, with headroom.
    localparam int SUM_W     = INT_W + 3;
    // Width of the clamp excess (limited minus sum).
    localparam int EXC_W     = SUM_W + 1;
    // Shared multiplier operands and product.
    localparam int MUL_A_W   = EXC_W;
    localparam int MUL_B_W   = 17;
    localparam int PROD_W    = MUL_A_W + MUL_B_W;
    // Integrator adder width: shifted product plus one bit of growth.
    localparam int ACC_W     = PROD_W - 8 + 1;
    // Duty limit of 100 percent in Q8.8.
    localparam int DUTY_LIMIT = 25600;

    // Configuration port.
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SETPOINT = 2'd0,
        CFG_KP       = 2'd1,
        CFG_KI       = 2'd2
    } t_cfg_idx;

    // Beat payloads.
    typedef struct packed {
        logic signed [15:0] measured_velocity;
        logic        [15:0] time_step;
    } t_in;

    typedef struct packed {
        logic signed [15:0] duty_command;
        logic               output_clamped;
    } t_out;

    // Control store.
    localparam int STEP_W = 3;

    typedef enum logic [1:0] {
        MA_ERR,
        MA_INT,
        MA_EXC
    } t_mula;

    typedef enum logic [1:0] {
        MB_DT,
        MB_KP,
        MB_KI
    } t_mulb;

    typedef enum logic [1:0] {
        JC_ALWAYS,
        JC_IN_VALID,
        JC_OUT_FREE
    } t_cond;

    typedef struct packed {
        logic              in_ready;
        logic              mul_en;
        t_mula             mula;
        t_mulb             mulb;
        logic              acc_en;
        logic              p_load;
        logic              sum_load;
        logic              clamp_load;
        logic              out_load;
        t_cond             cond;
        logic [STEP_W-1:0] next;
    } t_ctrl;

    // The program: one control word per step.
    function automatic t_ctrl ucode(input logic [STEP_W-1:0] step);
        t_ctrl w;
        w      = '0;
        w.mula = MA_ERR;
        w.mulb = MB_DT;
        w.cond = JC_ALWAYS;
        unique case (step)
            3'd0: begin
                // Wait for an input beat.
                w.in_ready = 1'b1;
                w.cond     = JC_IN_VALID;
                w.next     = 3'd1;
            end
            3'd1: begin
                // error times time step
                w.mul_en = 1'b1;
                w.mula   = MA_ERR;
                w.mulb   = MB_DT;
                w.next   = 3'd2;
            end
            3'd2: begin
                // Integrate, and form Kp times error.
                w.acc_en = 1'b1;
                w.mul_en = 1'b1;
                w.mula   = MA_ERR;
                w.mulb   = MB_KP;
                w.next   = 3'd3;
            end
            3'd3: begin
                // Keep the proportional term, and form Ki times integrator.
                w.p_load = 1'b1;
                w.mul_en = 1'b1;
                w.mula   = MA_INT;
                w.mulb   = MB_KI;
                w.next   = 3'd4;
            end
            3'd4: begin
                w.sum_load = 1'b1;
                w.next     = 3'd5;
            end
            3'd5: begin
                w.clamp_load = 1'b1;
                w.next       = 3'd6;
            end
            3'd6: begin
                // excess times time step
                w.mul_en = 1'b1;
                w.mula   = MA_EXC;
                w.mulb   = MB_DT;
                w.next   = 3'd7;
            end
            3'd7: begin
                // Back-calculation and result hand-off once the output is free.
                w.acc_en   = 1'b1;
                w.out_load = 1'b1;
                w.cond     = JC_OUT_FREE;
                w.next     = 3'd0;
            end
        endcase
        return w;
    endfunction

endpackage

// File: design/pi_velocity_controller_antiwindup_core.sv
// ============================================================================
// pi_velocity_controller_antiwindup_core: PI velocity controller
// Fixed-point PI controller with a saturating integrator and back-calculation
// anti-windup, run by a microcoded sequencer over a shared multiplier.
// ============================================================================
// Usage:
//   Input channel (i_in_valid / o_in_ready / i_in_data) carries one beat per
//   control step: measured velocity (Q8.8) and elapsed time step (Q0.16 s).
//   Output channel (o_out_valid / i_out_ready / o_out_data) returns one beat
//   per input beat: the clamped duty (Q8.8 percent) and a clamp flag.
//   Setpoint, Kp and Ki are written through i_cfg_we / i_cfg_idx /
//   i_cfg_data while the block is idle; unknown indexes are ignored.
//   Timing: an input beat is taken on step 0 of an eight-step program; the
//   result is loaded into the output register on step 7, and only then does
//   the program return to step 0 to take a new beat, so a beat is finished
//   before the next is accepted. The eight steps are set by the four passes
//   through the single shared multiplier plus the integrator, sum and clamp stages.
//   A result waiting in the output register does not stop the next beat from
//   being accepted and computed; only the final step holds until the output
//   register is free, so a stalled receiver delays the hand-off.
//   Reset (synchronous, active low) clears the gains, setpoint, integrator
//   and output valid, and restarts the program at step 0.
// ============================================================================
module pi_velocity_controller_antiwindup_core
    import pivc_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  t_in                   i_in_data,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output t_out                  o_out_data,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_ctrl ctrl;
    logic  out_free;

    // Program sequencer.
    pivc_seq u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_out_free (out_free),
        .o_ctrl     (ctrl)
    );

    // Arithmetic datapath.
    pivc_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctrl      (ctrl),
        .i_in_valid  (i_in_valid),
        .i_in_data   (i_in_data),
        .i_out_ready (i_out_ready),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .o_out_free  (out_free),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data)
    );

    assign o_in_ready = ctrl.in_ready;

endmodule

// File: design/pivc_seq.sv
// ============================================================================
// pivc_seq: microcode sequencer
// Step counter over the control store with conditional waits; the control
// word has its integrator and output load enables masked while a wait condition holds.
// ============================================================================
module pivc_seq
    import pivc_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_in_valid,
    input  logic  i_out_free,
    output t_ctrl o_ctrl
);

    logic [STEP_W-1:0] r_step;
    logic [STEP_W-1:0] n_step;
    t_ctrl             word;
    logic              go;

    // Fetch and condition test.
    always_comb begin
        word = ucode(r_step);
        unique case (word.cond)
            JC_ALWAYS:   go = 1'b1;
            JC_IN_VALID: go = i_in_valid;
            JC_OUT_FREE: go = i_out_free;
            default:     go = 1'b0;
        endcase
        n_step = go ? word.next : r_step;
        o_ctrl = word;
        if (!go) begin
            o_ctrl.acc_en   = 1'b0;
            o_ctrl.out_load = 1'b0;
        end
    end

    // Step counter.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= '0;
        end else begin
            r_step <= n_step;
        end
    end

endmodule

// File: design/pivc_dp.sv
// ============================================================================
// pivc_dp: datapath of the PI velocity core
// Configuration registers, input capture, one shared multiplier, the
// saturating integrator, the sum, the clamp and the output register.
// ============================================================================
module pivc_dp
    import pivc_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_ctrl                 i_ctrl,
    input  logic                  i_in_valid,
    input  t_in                   i_in_data,
    input  logic                  i_out_ready,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output logic                  o_out_free,
    output logic                  o_out_valid,
    output t_out                  o_out_data
);

    localparam logic signed [SUM_W-1:0] SumHi = SUM_W'(DUTY_LIMIT);
    localparam logic signed [SUM_W-1:0] SumLo = -SumHi;
    localparam logic signed [15:0]      DutyHi = 16'(DUTY_LIMIT);
    localparam logic signed [15:0]      DutyLo = -DutyHi;
    localparam logic signed [INT_W-1:0] IntMax = {1'b0, {(INT_W-1){1'b1}}};
    localparam logic signed [INT_W-1:0] IntMin = {1'b1, {(INT_W-1){1'b0}}};

    logic signed [15:0]        r_setpoint;
    logic        [15:0]        r_kp;
    logic        [15:0]        r_ki;
    logic signed [15:0]        r_meas;
    logic        [15:0]        r_dt;
    logic signed [INT_W-1:0]   r_integ;
    logic signed [PROD_W-1:0]  r_prod;
    logic signed [SUM_W-1:0]   r_p;
    logic signed [SUM_W-1:0]   r_sum;
    logic signed [15:0]        r_limited;
    logic                      r_clamped;
    logic signed [EXC_W-1:0]   r_excess;
    logic                      r_out_valid;
    t_out                      r_out;

    logic signed [16:0]        err;
    logic signed [MUL_A_W-1:0] mul_a;
    logic signed [MUL_B_W-1:0] mul_b;
    logic signed [PROD_W-1:0]  n_prod;
    logic signed [PROD_W-1:0]  prod_sh8;
    logic signed [PROD_W-1:0]  prod_sh16;
    logic signed [ACC_W-1:0]   acc_add;
    logic signed [INT_W-1:0]   n_integ;
    logic signed [15:0]        n_limited;
    logic                      n_clamped;

    // Error, operand selection and the shared multiplier.
    always_comb begin
        err = $signed({r_setpoint[15], r_setpoint}) - $signed({r_meas[15], r_meas});
        case (i_ctrl.mula)
            MA_ERR:  mul_a = MUL_A_W'(err);
            MA_INT:  mul_a = MUL_A_W'(r_integ);
            MA_EXC:  mul_a = r_excess;
            default: mul_a = '0;
        endcase
        case (i_ctrl.mulb)
            MB_DT:   mul_b = $signed({1'b0, r_dt});
            MB_KP:   mul_b = $signed({1'b0, r_kp});
            MB_KI:   mul_b = $signed({1'b0, r_ki});
            default: mul_b = '0;
        endcase
        n_prod    = mul_a * mul_b;
        prod_sh8  = r_prod >>> 8;
        prod_sh16 = r_prod >>> 16;
    end

    // Integrator add with saturation to its signed range.
    always_comb begin
        acc_add = ACC_W'(r_integ) + $signed(prod_sh8[ACC_W-1:0]);
        if ((&acc_add[ACC_W-1:INT_W-1]) || !(|acc_add[ACC_W-1:INT_W-1])) begin
            n_integ = acc_add[INT_W-1:0];
        end else if (acc_add[ACC_W-1]) begin
            n_integ = IntMin;
        end else begin
            n_integ = IntMax;
        end
    end

    // Clamp of the sum to plus or minus 100 percent.
    always_comb begin
        if (r_sum > SumHi) begin
            n_limited = DutyHi;
            n_clamped = 1'b1;
        end else if (r_sum < SumLo) begin
            n_limited = DutyLo;
            n_clamped = 1'b1;
        end else begin
            n_limited = r_sum[15:0];
            n_clamped = 1'b0;
        end
    end

    // Control state: configuration, integrator and output valid.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_setpoint  <= '0;
            r_kp        <= '0;
            r_ki        <= '0;
            r_integ     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_SETPOINT: r_setpoint <= $signed(i_cfg_data);
                    CFG_KP:       r_kp       <= i_cfg_data;
                    CFG_KI:       r_ki       <= i_cfg_data;
                    default:      ;
                endcase
            end
            if (i_ctrl.acc_en) begin
                r_integ <= n_integ;
            end
            if (i_ctrl.out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (i_ctrl.in_ready && i_in_valid) begin
            r_meas <= i_in_data.measured_velocity;
            r_dt   <= i_in_data.time_step;
        end
        if (i_ctrl.mul_en) begin
            r_prod <= n_prod;
        end
        if (i_ctrl.p_load) begin
            r_p <= $signed(prod_sh8[SUM_W-1:0]);
        end
        if (i_ctrl.sum_load) begin
            r_sum <= r_p + $signed(prod_sh16[SUM_W-1:0]);
        end
        if (i_ctrl.clamp_load) begin
            r_limited <= n_limited;
            r_clamped <= n_clamped;
            r_excess  <= EXC_W'(n_limited) - EXC_W'(r_sum);
        end
        if (i_ctrl.out_load) begin
            r_out.duty_command   <= r_limited;
            r_out.output_clamped <= r_clamped;
        end
    end

    assign o_out_free  = !r_out_valid || i_out_ready;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

`ifndef SYNTHESIS
    // The integrator moves only on its two update steps.
    a_integ_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_ctrl.acc_en |=> $stable(r_integ))
        else $error("integrator changed outside an update step");

    // A result appears only when the program hands one over.
    a_out_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(i_ctrl.out_load))
        else $error("output valid rose without a hand-off");

    // A pending result is never overwritten.
    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctrl.out_load |-> (!r_out_valid || i_out_ready))
        else $error("result loaded over a pending beat");

    // A clamped result sits exactly on a limit.
    a_clamp_rail: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.output_clamped) |->
            (r_out.duty_command == DutyHi || r_out.duty_command == DutyLo))
        else $error("clamped duty is not on a limit");
`endif

endmodule

// File: tb/pivc_duty_checker.sv
`timescale 1ns / 1ps
// ============================================================================
// pivc_duty_checker: duty prediction and result checking for the PI core
// Watches the configuration port and both beat channels. For every accepted
// input beat it computes the clamped duty and clamp flag with its own copy of
// the gains, setpoint and saturating integrator, and checks each output beat
// in order against the oldest prediction.
// ============================================================================
module pivc_duty_checker
    import pivc_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    input  logic                  i_in_ready,
    input  t_in                   i_in_data,
    input  logic                  i_out_valid,
    input  logic                  i_out_ready,
    input  t_out                  i_out_data,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output int                    o_fail_count,
    output int                    o_pending
);

    localparam longint INTEG_MAX = (longint'(1) <<< (INT_W - 1)) - 1;
    localparam longint INTEG_MIN = -INTEG_MAX - 1;

    // Shadow copy of the controller registers and state.
    logic signed [15:0] setpoint_q;
    logic        [15:0] kp_q;
    logic        [15:0] ki_q;
    longint             integ_q;

    t_out duty_queue[$];
    int   mismatches;

    // Saturate a value to the signed integrator range.
    function automatic longint clip_integ(input longint v);
        if (v > INTEG_MAX) begin
            return INTEG_MAX;
        end
        if (v < INTEG_MIN) begin
            return INTEG_MIN;
        end
        return v;
    endfunction

    // One control step: integrate, form P and I terms, clamp, then feed the
    // clamp excess back into the integrator. Arithmetic shifts of signed
    // values round toward minus infinity.
    function automatic t_out predict_duty(input t_in beat);
        longint err;
        longint dt;
        longint p_term;
        longint i_term;
        longint total;
        longint limited;
        longint excess;
        t_out   res;
        err     = longint'($signed(setpoint_q)) - longint'($signed(beat.measured_velocity));
        dt      = longint'({1'b0, beat.time_step});
        integ_q = clip_integ(integ_q + ((err * dt) >>> 8));
        p_term  = (longint'({1'b0, kp_q}) * err) >>> 8;
        i_term  = (longint'({1'b0, ki_q}) * integ_q) >>> 16;
        total   = p_term + i_term;
        limited = total;
        res.output_clamped = 1'b0;
        if (total > DUTY_LIMIT) begin
            limited = DUTY_LIMIT;
            res.output_clamped = 1'b1;
        end else if (total < -DUTY_LIMIT) begin
            limited = -DUTY_LIMIT;
            res.output_clamped = 1'b1;
        end
        excess  = limited - total;
        integ_q = clip_integ(integ_q + ((excess * dt) >>> 8));
        res.duty_command = limited[15:0];
        return res;
    endfunction

    initial begin
        mismatches = 0;
    end

    always @(posedge i_clk) begin
        t_out want;
        if (!i_rst_n) begin
            setpoint_q = '0;
            kp_q       = '0;
            ki_q       = '0;
            integ_q    = 0;
            duty_queue.delete();
        end else begin
            // Register writes; unknown indexes leave everything alone.
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_SETPOINT: setpoint_q = i_cfg_data;
                    CFG_KP:       kp_q       = i_cfg_data;
                    CFG_KI:       ki_q       = i_cfg_data;
                    default: ;
                endcase
            end

            // Output beat against the oldest prediction.
            if (i_out_valid && i_out_ready) begin
                if (duty_queue.size() == 0) begin
                    mismatches++;
                    $display("%0t: unexpected output beat: expected none, actual duty %0d flag %0b",
                             $time, i_out_data.duty_command, i_out_data.output_clamped);
                end else begin
                    want = duty_queue.pop_front();
                    if (i_out_data.duty_command !== want.duty_command) begin
                        mismatches++;
                        $display("%0t: duty mismatch: expected %0d, actual %0d",
                                 $time, want.duty_command, i_out_data.duty_command);
                    end
                    if (i_out_data.output_clamped !== want.output_clamped) begin
                        mismatches++;
                        $display("%0t: clamp flag mismatch: expected %0b, actual %0b",
                                 $time, want.output_clamped, i_out_data.output_clamped);
                    end
                end
            end

            // Input beat: predict its result.
            if (i_in_valid && i_in_ready) begin
                duty_queue.push_back(predict_duty(i_in_data));
            end
        end
        o_fail_count <= mismatches;
        o_pending    <= duty_queue.size();
    end

endmodule

// File: tb/pi_velocity_controller_antiwindup_core_tb.sv
`timescale 1ns / 1ps
// ============================================================================
// pi_velocity_controller_antiwindup_core_tb: testbench for the PI core
// Drives measurement beats under random stalls on both channels through a
// series of gain and setpoint settings, starting with directed extremes
// (integrator saturation both ways, zero steps, zero gains, unknown register
// index), and lets the duty checker compare every result beat.
// ============================================================================
module pi_velocity_controller_antiwindup_core_tb
    import pivc_pkg::*;
();

    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;
    localparam int ITEM_TARGET = 700;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_in_valid;
    logic                  o_in_ready;
    t_in                   i_in_data;
    logic                  o_out_valid;
    logic                  i_out_ready;
    t_out                  o_out_data;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    int fail_count;
    int pending;

    logic signed [15:0] cur_setpoint;
    bit                 steady_in;
    int                 sent;

    pi_velocity_controller_antiwindup_core dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data)
    );

    pivc_duty_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .i_in_ready   (o_in_ready),
        .i_in_data    (i_in_data),
        .i_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .i_out_data   (o_out_data),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    // Clock.
    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // Hard stop in case the block hangs.
    initial begin
        #10_000_000;
        $display("TB_ERROR");
        $finish;
    end

    // Receiver: ready runs broken by stalls, mostly short, a few long,
    // with occasional long stretches of no stalling at all.
    initial begin
        int run_len;
        int stall_len;
        int r;
        i_out_ready = 1'b0;
        @(negedge i_clk);
        forever begin
            run_len = ($urandom_range(0, 9) == 0) ? $urandom_range(150, 400)
                                                  : $urandom_range(1, 20);
            i_out_ready <= 1'b1;
            repeat (run_len) @(negedge i_clk);
            r = $urandom_range(0, 99);
            if (r < 40) begin
                stall_len = 0;
            end else if (r < 85) begin
                stall_len = $urandom_range(1, 4);
            end else begin
                stall_len = $urandom_range(20, 80);
            end
            if (stall_len > 0) begin
                i_out_ready <= 1'b0;
                repeat (stall_len) @(negedge i_clk);
            end
        end
    end

    // Gap ahead of an input beat.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (steady_in || r < 55) begin
            return 0;
        end
        if (r < 90) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(10, 40);
    endfunction

    function automatic logic [15:0] pick_gain();
        case ($urandom_range(0, 5))
            0:       return 16'h0000;
            1:       return 16'hFFFF;
            2, 3:    return 16'($urandom_range(0, 1024));
            default: return 16'($urandom_range(0, 65535));
        endcase
    endfunction

    function automatic logic [15:0] pick_setpoint();
        case ($urandom_range(0, 5))
            0:       return 16'h8000;
            1:       return 16'h7FFF;
            2, 3:    return 16'($urandom_range(0, 4095) - 2048);
            default: return 16'($urandom_range(0, 65535));
        endcase
    endfunction

    function automatic logic [15:0] pick_step();
        case ($urandom_range(0, 9))
            0:             return 16'h0000;
            1:             return 16'hFFFF;
            2, 3, 4, 5, 6: return 16'($urandom_range(1, 3000));
            default:       return 16'($urandom_range(0, 65535));
        endcase
    endfunction

    // Measurement: mostly close to the setpoint, so the loop runs unclamped
    // and the integrator matters, plus wide and extreme values.
    function automatic logic [15:0] pick_measurement();
        int r;
        int v;
        r = $urandom_range(0, 99);
        if (r < 60) begin
            v = int'(cur_setpoint) + int'($urandom_range(0, 1023)) - 512;
            if (v > 32767) begin
                v = 32767;
            end else if (v < -32768) begin
                v = -32768;
            end
            return 16'(v);
        end
        if (r < 85) begin
            return 16'($urandom_range(0, 65535));
        end
        return ($urandom_range(0, 1) == 0) ? 16'h8000 : 16'h7FFF;
    endfunction

    // Send one measurement beat; called and returning at a falling edge.
    task automatic send_sample(input logic [15:0] meas, input logic [15:0] dt);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid                  <= 1'b1;
        i_in_data.measured_velocity <= meas;
        i_in_data.time_step         <= dt;
        do @(posedge i_clk); while (!o_in_ready);
        @(negedge i_clk);
    endtask

    // Wait until every predicted result has come back and the core is idle.
    task automatic wait_idle();
        i_in_valid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (12) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] value);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= value;
        @(negedge i_clk);
        i_cfg_we   <= 1'b0;
        @(negedge i_clk);
    endtask

    task automatic configure(input logic [15:0] sp, input logic [15:0] kp,
                             input logic [15:0] ki);
        wait_idle();
        write_reg(CFG_SETPOINT, sp);
        write_reg(CFG_KP, kp);
        write_reg(CFG_KI, ki);
        cur_setpoint = sp;
    endtask

    // Stimulus.
    initial begin
        int n_items;
        i_rst_n      = 1'b0;
        i_in_valid   = 1'b0;
        i_in_data    = '0;
        i_cfg_we     = 1'b0;
        i_cfg_idx    = '0;
        i_cfg_data   = '0;
        cur_setpoint = '0;
        steady_in    = 1'b0;
        sent         = 0;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Reset settings: zero gains give zero duty while the integrator runs.
        send_sample(16'h8000, 16'hFFFF);
        send_sample(16'h7FFF, 16'h0000);
        send_sample(16'h0000, 16'h0001);
        send_sample(16'h3039, 16'hFFFF);

        // Full positive error with only Kp: clamp excess drives the
        // integrator to its negative limit; then a zero step.
        configure(16'h7FFF, 16'hFFFF, 16'h0000);
        write_reg(CFG_UNUSED, 16'hFFFF);
        send_sample(16'h8000, 16'hFFFF);
        send_sample(16'h8000, 16'h0000);
        send_sample(16'h7FFF, 16'hFFFF);

        // Full negative error with both gains at maximum: positive limit.
        configure(16'h8000, 16'hFFFF, 16'hFFFF);
        send_sample(16'h7FFF, 16'hFFFF);
        send_sample(16'h7FFF, 16'hFFFF);
        send_sample(16'h8000, 16'h0064);
        send_sample(16'h0000, 16'h0000);

        // Unit gains, small errors, alternating bit patterns.
        configure(16'h0000, 16'h0100, 16'h0100);
        write_reg(CFG_UNUSED, 16'h0000);
        send_sample(16'h0100, 16'd1000);
        send_sample(16'hFF00, 16'd1000);
        send_sample(16'h0000, 16'hFFFF);
        send_sample(16'h0001, 16'h0001);
        send_sample(16'hFFFF, 16'hFFFF);
        send_sample(16'h5555, 16'hAAAA);
        send_sample(16'hAAAA, 16'h5555);

        // Random settings, each followed by a run of control steps.
        while (sent < ITEM_TARGET) begin
            configure(pick_setpoint(), pick_gain(), pick_gain());
            if ($urandom_range(0, 4) == 0) begin
                write_reg(CFG_UNUSED, 16'($urandom_range(0, 65535)));
            end
            steady_in = ($urandom_range(0, 3) == 0);
            n_items   = $urandom_range(40, 100);
            repeat (n_items) begin
                send_sample(pick_measurement(), pick_step());
                sent++;
            end
        end
        steady_in = 1'b0;

        wait_idle();
        if (fail_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
